// ===== sv/genotype_cell_fold_counter_macros.svh =====
// Assertion macros for the counter RTL.
`ifndef GENOTYPE_CELL_FOLD_COUNTER_MACROS_SVH
`define GENOTYPE_CELL_FOLD_COUNTER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define GCFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define GCFC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/gcfc_pkg.sv =====
// Shared types, constants and helpers of the genotype cell fold counter.
`timescale 1ns / 1ps

package gcfc_pkg;

  localparam int MAX_ORDER_DEF = 4;
  localparam int FOLD_CNT_DEF  = 16;

  localparam int GENO_FIELDS = 4;
  localparam int FOLD_BITS   = 16;
  localparam int COUNT_W     = 16;
  localparam int ORDER_W     = 3;
  localparam int CELL_W      = 7;   // largest cell index is 80 (four SNPs)

  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [1:0]         GENO_MISSING    = 2'd3;
  localparam logic [ORDER_W-1:0] SNP_ORDER_RESET = 3'd2;

  typedef enum logic [1:0] {
    FUNC_ACC   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]           func;
    logic [1:0]           geno_0;
    logic [1:0]           geno_1;
    logic [1:0]           geno_2;
    logic [1:0]           geno_3;
    logic                 is_affected;
    logic [FOLD_BITS-1:0] fold_bits;
    logic [3:0]           read_fold;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_value;
    logic               count_saturated;
  } rsp_t;

  typedef logic [ORDER_W-1:0] cfg_t;

  // decoded genotype tuple
  typedef struct packed {
    logic              missing;
    logic [CELL_W-1:0] idx;
  } cell_t;

  function automatic int pow3(int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 3;
    end
    return r;
  endfunction

endpackage

// ===== sv/gcfc_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps

interface gcfc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gcfc_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module gcfc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gcfc_cell_index.sv =====
// Genotype tuple to cell index decode, with missing-genotype detection.
`timescale 1ns / 1ps

module gcfc_cell_index #(
  parameter int MAX_ORDER = gcfc_pkg::MAX_ORDER_DEF
) (
  input  gcfc_pkg::req_t                    req_i,
  input  logic [gcfc_pkg::ORDER_W-1:0]      snp_order_i,
  output gcfc_pkg::cell_t                   cell_o
);

  localparam int ORDER_CAP =
    (MAX_ORDER < gcfc_pkg::GENO_FIELDS) ? MAX_ORDER : gcfc_pkg::GENO_FIELDS;

  localparam logic [gcfc_pkg::CELL_W-1:0] WEIGHT [gcfc_pkg::GENO_FIELDS] =
    '{7'd1, 7'd3, 7'd9, 7'd27};

  logic [gcfc_pkg::ORDER_W-1:0] order;
  logic [1:0]                   geno [gcfc_pkg::GENO_FIELDS];

  assign geno[0] = req_i.geno_0;
  assign geno[1] = req_i.geno_1;
  assign geno[2] = req_i.geno_2;
  assign geno[3] = req_i.geno_3;

  // clamp order into 1..cap
  always_comb begin
    order = snp_order_i;
    if (order == '0) begin
      order = gcfc_pkg::ORDER_W'(1);
    end
    if (order > gcfc_pkg::ORDER_W'(ORDER_CAP)) begin
      order = gcfc_pkg::ORDER_W'(ORDER_CAP);
    end
  end

  always_comb begin
    cell_o = '0;
    for (int j = 0; j < gcfc_pkg::GENO_FIELDS; j++) begin
      if (gcfc_pkg::ORDER_W'(j) < order) begin
        if (geno[j] == gcfc_pkg::GENO_MISSING) begin
          cell_o.missing = 1'b1;
        end
        cell_o.idx = cell_o.idx + (gcfc_pkg::CELL_W'(geno[j]) * WEIGHT[j]);
      end
    end
  end

endmodule

// ===== sv/gcfc_row_update.sv =====
// Per-fold saturating increment of one counter row and fold select for reads.
`timescale 1ns / 1ps

module gcfc_row_update #(
  parameter int FOLD_CNT = gcfc_pkg::FOLD_CNT_DEF
) (
  input  logic [FOLD_CNT*gcfc_pkg::COUNT_W-1:0] row_i,
  input  logic [gcfc_pkg::FOLD_BITS-1:0]        fold_bits_i,
  input  logic [3:0]                            read_fold_i,
  output logic [FOLD_CNT*gcfc_pkg::COUNT_W-1:0] row_o,
  output logic [gcfc_pkg::COUNT_W-1:0]          count_o
);

  localparam int W = gcfc_pkg::COUNT_W;

  for (genvar f = 0; f < FOLD_CNT; f++) begin : g_lane
    logic [W-1:0] cur;
    assign cur = row_i[f*W +: W];
    if (f < gcfc_pkg::FOLD_BITS) begin : g_cnt
      assign row_o[f*W +: W] =
        (fold_bits_i[f] && (cur != gcfc_pkg::COUNT_MAX)) ? cur + 1'b1 : cur;
    end else begin : g_keep
      // no fold bit reaches this lane
      assign row_o[f*W +: W] = cur;
    end
  end

  always_comb begin
    count_o = '0;
    for (int f = 0; f < FOLD_CNT; f++) begin
      if (32'(read_fold_i) == f) begin
        count_o = row_i[f*W +: W];
      end
    end
  end

endmodule

// ===== sv/genotype_cell_fold_counter.sv =====
// Top level: contingency counters per fold, genotype cell and class.
//
//  channel | dir | payload                                        | request means
//  --------+-----+------------------------------------------------+------------------------
//  req_i   | in  | func, geno_0..3, is_affected, fold_bits, read_fold | accumulate/read/clear
//  rsp_o   | out | count_value, count_saturated                   | one result per read
//  cfg_i   | in  | snp_order (3 bits)                             | register write
//
//  Accumulate and read do one RAM read, then write-back or fold select.
//  That is the round trip of the single counter RAM; the FSM keeps one request in flight.
//  Missing-genotype accumulates and unknown codes finish in the accept cycle.
//  Clear and reset sweep all 2*3^MAX_ORDER RAM rows (162 by default), no requests taken.
//  A read result waits in rsp_o; a later read stalls only if that slot is still full.
//  cfg_i is always ready.
`timescale 1ns / 1ps
`include "genotype_cell_fold_counter_macros.svh"

module genotype_cell_fold_counter #(
  parameter int MAX_ORDER = gcfc_pkg::MAX_ORDER_DEF,
  parameter int FOLD_CNT  = gcfc_pkg::FOLD_CNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gcfc_stream_if.sink   req_i,
  gcfc_stream_if.source rsp_o,
  gcfc_stream_if.sink   cfg_i
);

  // one RAM row holds all fold counters of one (cell, class) pair
  localparam int CELLS   = gcfc_pkg::pow3(MAX_ORDER);
  localparam int ROWS    = 2 * CELLS;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int CELL_AW = ROW_AW - 1;
  localparam int ROW_W   = FOLD_CNT * gcfc_pkg::COUNT_W;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_MODIFY = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [ROW_AW-1:0] clr_row_q, clr_row_d;
  logic [gcfc_pkg::ORDER_W-1:0] snp_order_q;

  // request held for the modify cycle
  logic                           op_read_q;
  logic                           zero_q;
  logic [ROW_AW-1:0]              row_q;
  logic [gcfc_pkg::FOLD_BITS-1:0] fold_bits_q;
  logic [3:0]                     read_fold_q;

  logic           rsp_valid_q, rsp_valid_d;
  gcfc_pkg::rsp_t rsp_q, rsp_d;

  gcfc_pkg::cell_t    cell_info;
  logic [ROW_AW-1:0]  row_in;
  logic               rfold_ok;
  logic               req_fire;

  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata, upd_row;
  logic [gcfc_pkg::COUNT_W-1:0] sel_count;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  gcfc_cell_index #(
    .MAX_ORDER (MAX_ORDER)
  ) u_cell_index (
    .req_i       (req_i.data),
    .snp_order_i (snp_order_q),
    .cell_o      (cell_info)
  );

  assign row_in   = {CELL_AW'(cell_info.idx), req_i.data.is_affected};
  assign rfold_ok = 32'(req_i.data.read_fold) < FOLD_CNT;

  gcfc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (row_in),
    .rdata_o (ram_rdata)
  );

  gcfc_row_update #(
    .FOLD_CNT (FOLD_CNT)
  ) u_row_update (
    .row_i       (ram_rdata),
    .fold_bits_i (fold_bits_q),
    .read_fold_i (read_fold_q),
    .row_o       (upd_row),
    .count_o     (sel_count)
  );

  // Write-back lands before the next request is accepted, so a following
  // read of the same row already sees it: no forwarding path needed.
  always_comb begin
    state_d     = state_q;
    clr_row_d   = clr_row_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = row_q;
    ram_wdata   = upd_row;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_row_q;
        ram_wdata = '0;
        if (clr_row_q == LAST_ROW) begin
          clr_row_d = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_row_d = clr_row_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          case (req_i.data.func)
            gcfc_pkg::FUNC_ACC: begin
              if (!cell_info.missing) begin
                ram_re  = 1'b1;
                state_d = ST_MODIFY;
              end
            end
            gcfc_pkg::FUNC_READ: begin
              ram_re  = 1'b1;
              state_d = ST_MODIFY;
            end
            gcfc_pkg::FUNC_CLEAR: state_d = ST_CLEAR;
            default: ;
          endcase
        end
      end
      ST_MODIFY: begin
        if (!op_read_q) begin
          ram_we  = 1'b1;
          state_d = ST_IDLE;
        end else if (!rsp_valid_q || rsp_o.ready) begin
          // RAM read data holds while we wait for the result slot
          rsp_valid_d           = 1'b1;
          rsp_d.count_value     = zero_q ? '0 : sel_count;
          rsp_d.count_saturated = !zero_q && (sel_count == gcfc_pkg::COUNT_MAX);
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_row_q   <= '0;
      rsp_valid_q <= 1'b0;
      snp_order_q <= gcfc_pkg::SNP_ORDER_RESET;
    end else begin
      state_q     <= state_d;
      clr_row_q   <= clr_row_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        snp_order_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (req_fire) begin
      op_read_q   <= (req_i.data.func == gcfc_pkg::FUNC_READ);
      zero_q      <= cell_info.missing || !rfold_ok;
      row_q       <= row_in;
      fold_bits_q <= req_i.data.fold_bits;
      read_fold_q <= req_i.data.read_fold;
    end
  end

  `GCFC_ASSERT(a_read_enters_modify,
    req_fire && (req_i.data.func == gcfc_pkg::FUNC_READ) |=> (state_q == ST_MODIFY) && op_read_q,
    "read request did not enter modify")
  `GCFC_ASSERT_NEVER(a_ram_rw_overlap, ram_we && ram_re, "RAM read and write in same cycle")
  `GCFC_ASSERT(a_clear_ends, (state_q == ST_CLEAR) && (clr_row_q == LAST_ROW) |=> state_q == ST_IDLE,
    "clear sweep did not end at last row")
  `GCFC_ASSERT(a_read_waits,
    (state_q == ST_MODIFY) && op_read_q && rsp_valid_q && !rsp_o.ready |=> state_q == ST_MODIFY,
    "read result dropped while output slot full")

endmodule
